### sv/ffbh_pkg.sv
// ============================================================================
// ffbh_pkg
// Shared types and constants for the first-fit block heap.
// ============================================================================
`default_nettype none

package ffbh_pkg;

   // Geometry: one 32-byte header slot in front of every block.
   localparam int          HDR_BYTES  = 32;
   localparam logic [16:0] HDR_ADD    = 17'd32;
   localparam logic [16:0] ALIGN_MASK = ~17'd31;

   // Action codes carried in the request beat.
   localparam logic [1:0] ACT_CREATE = 2'd0;
   localparam logic [1:0] ACT_ALLOC  = 2'd1;
   localparam logic [1:0] ACT_FREE   = 2'd2;

   // Status codes carried in the response beat.
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NOFIT    = 2'd1;
   localparam logic [1:0] STAT_BADFREE  = 2'd2;
   localparam logic [1:0] STAT_NULLFREE = 2'd3;

   // Header tags.
   localparam logic [1:0] TAG_NONE = 2'd0;
   localparam logic [1:0] TAG_FREE = 2'd1;
   localparam logic [1:0] TAG_USED = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] lo_addr;
      logic [16:0] hi_addr;
      logic [15:0] heap_handle;
      logic [15:0] request_bytes;
      logic [15:0] release_ptr;
   } ffbh_req_type;

   typedef struct packed {
      logic [15:0] result_addr;
      logic [1:0]  status;
   } ffbh_rsp_type;

   typedef struct packed {
      logic [1:0]  tag;
      logic [15:0] size;
   } ffbh_hdr_type;

   // Results of the shared walk unit for the block under inspection.
   typedef struct packed {
      logic [17:0] blk_end;   // cur + header + size
      logic [16:0] nxt_addr;  // header address of a split remainder
      logic [15:0] rem_size;  // payload size of a split remainder
      logic        in_heap;   // cur + header still below heap end
      logic        past_end;  // block runs past heap end
      logic        fits;      // block size covers the request
      logic        split;     // more than one header left over
   } ffbh_alu_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_WALK,
      S_CHECK,
      S_SPLIT,
      S_DONE
   } ffbh_state_type;

endpackage

`default_nettype wire

### sv/ffbh_alu.sv
// ============================================================================
// ffbh_alu
// Shared address and size arithmetic used on every step of the block walk.
// ============================================================================
`default_nettype none

module ffbh_alu (
   input  wire logic [16:0]          cur,
   input  wire logic [15:0]          size,
   input  wire logic [16:0]          need,
   input  wire logic [16:0]          heap_end,
   output ffbh_pkg::ffbh_alu_type    res
);
   import ffbh_pkg::*;

   logic [17:0] hdr_end;
   logic [17:0] nxt_full;

   assign hdr_end  = 18'(cur) + 18'(HDR_ADD);
   assign nxt_full = hdr_end + 18'(need);

   always_comb begin
      res.blk_end  = hdr_end + 18'(size);
      res.nxt_addr = nxt_full[16:0];
      res.rem_size = size - need[15:0] - 16'(HDR_BYTES);
      res.in_heap  = hdr_end < 18'(heap_end);
      res.past_end = (hdr_end + 18'(size)) > 18'(heap_end);
      res.fits     = 17'(size) >= need;
      res.split    = 18'(size) > (18'(need) + 18'(HDR_ADD));
   end

endmodule

`default_nettype wire

### sv/first_fit_block_heap.sv
// ============================================================================
// first_fit_block_heap
// First-fit heap allocator with a 32-byte header in front of every block.
// ============================================================================
// Sequence: each request passes S_START and S_DONE; a create, a rejected request or a
// malformed free reads no header. A free adds S_WALK and S_CHECK to read its header;
// an allocate adds one S_WALK/S_CHECK pair per header inspected, one S_WALK when the
// walk reaches the heap end and S_SPLIT when the chosen block is split. A new request
// is taken only in S_IDLE, after S_DONE has moved the last result to the response register.
// Reset: a clearing pass writes all MEM_SLOTS slots (at most 2048), one a cycle.
// ============================================================================
`default_nettype none

module first_fit_block_heap #(
   parameter int SPACE_BYTES = 65536
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire ffbh_pkg::ffbh_req_type req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output ffbh_pkg::ffbh_rsp_type      rsp_payload
);
   import ffbh_pkg::*;

   // Only the first 64 KiB of the space can ever hold a header, so the
   // memory covers at most that many slots.
   localparam int          LIMIT_BYTES = (SPACE_BYTES < 65536) ? SPACE_BYTES : 65536;
   localparam int          MEM_SLOTS   = LIMIT_BYTES / HDR_BYTES;
   localparam int          SLOT_W      = $clog2(MEM_SLOTS);
   localparam int          SLOT_COUNT  = SPACE_BYTES / HDR_BYTES;
   localparam logic [16:0] LIMIT_VAL   = 17'(LIMIT_BYTES);
   localparam logic [16:0] SLOT_LIM    = 17'(SLOT_COUNT);

   // Sequencer state and the request under work.
   ffbh_state_type state_ff, state_in;
   ffbh_req_type   req_ff, req_in;

   // Walk pointer, rounded request size and the end of the live heap.
   logic [16:0] cur_ff, cur_in;
   logic [16:0] need_ff, need_in;
   logic [16:0] heap_end_ff, heap_end_in;

   // Pending result, and the response output register.
   logic [15:0]  res_addr_ff, res_addr_in;
   logic [1:0]   res_stat_ff, res_stat_in;
   ffbh_rsp_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   // Clearing pass counter.
   logic [SLOT_W-1:0] clr_ff, clr_in;

   // Header memory: one write port, one registered read port.
   ffbh_hdr_type      mem [MEM_SLOTS];
   ffbh_hdr_type      rd_hdr_ff;
   logic              mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   ffbh_hdr_type      mem_wdata;
   logic [SLOT_W-1:0] mem_raddr;

   ffbh_alu_type alu_res;

   // Create arithmetic.
   logic [16:0] c_start;
   logic [16:0] c_hi;
   logic [16:0] c_span;

   // Free pointer arithmetic.
   logic [15:0] f_off;

   ffbh_alu u_alu (
      .cur      (cur_ff),
      .size     (rd_hdr_ff.size),
      .need     (need_ff),
      .heap_end (heap_end_ff),
      .res      (alu_res)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The read port always looks at the header under the walk pointer; the
   // data is used in the cycle after the pointer is set up.
   assign mem_raddr = cur_ff[SLOT_W+4:5];

   // Region alignment: start rounds up, the span rounds down.
   assign c_start = ({1'b0, req_ff.lo_addr} + 17'd31) & ALIGN_MASK;
   assign c_hi    = (req_ff.hi_addr > LIMIT_VAL) ? LIMIT_VAL : req_ff.hi_addr;
   assign c_span  = (c_hi - c_start) & ALIGN_MASK;

   // A payload pointer sits one header past its block header.
   assign f_off = req_ff.release_ptr - 16'(HDR_BYTES);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_hdr_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         heap_end_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         heap_end_ff  <= heap_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      cur_ff      <= cur_in;
      need_ff     <= need_in;
      res_addr_ff <= res_addr_in;
      res_stat_ff <= res_stat_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cur_in       = cur_ff;
      need_in      = need_ff;
      heap_end_in  = heap_end_ff;
      res_addr_in  = res_addr_ff;
      res_stat_in  = res_stat_ff;
      clr_in       = clr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      mem_we       = 1'b0;
      mem_waddr    = cur_ff[SLOT_W+4:5];
      mem_wdata    = '0;

      case (state_ff)
         // Wipe every header to "no tag, size zero" after reset.
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + SLOT_W'(1);
            if (clr_ff == SLOT_W'(MEM_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_START;
            end
         end

         // Decode the action and do everything that needs no header read.
         S_START: begin
            res_addr_in = '0;
            res_stat_in = STAT_NOFIT;
            state_in    = S_DONE;
            case (req_ff.action)
               ACT_CREATE: begin
                  // The region must hold at least one header after rounding.
                  if (c_hi >= c_start && c_span >= HDR_ADD) begin
                     mem_we         = 1'b1;
                     mem_waddr      = c_start[SLOT_W+4:5];
                     mem_wdata.tag  = TAG_FREE;
                     mem_wdata.size = 16'(c_span - HDR_ADD);
                     heap_end_in    = c_start + c_span;
                     res_addr_in    = c_start[15:0];
                     res_stat_in    = STAT_OK;
                  end
               end
               ACT_ALLOC: begin
                  need_in = (17'(req_ff.request_bytes) + 17'd31) & ALIGN_MASK;
                  cur_in  = {1'b0, req_ff.heap_handle};
                  // A null or unaligned handle names no heap.
                  if (req_ff.heap_handle != '0 && req_ff.heap_handle[4:0] == '0) begin
                     state_in = S_WALK;
                  end
               end
               ACT_FREE: begin
                  cur_in = {1'b0, f_off};
                  if (req_ff.release_ptr == '0) begin
                     res_stat_in = STAT_NULLFREE;
                  end else begin
                     res_stat_in = STAT_BADFREE;
                     if (req_ff.release_ptr >= 16'(HDR_BYTES) &&
                         req_ff.release_ptr[4:0] == '0 &&
                         {6'd0, f_off[15:5]} < SLOT_LIM) begin
                        state_in = S_WALK;
                     end
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // The header read is under way; an allocate's walk ends once the next
         // header would not sit below the heap end.
         S_WALK: begin
            if (req_ff.action == ACT_ALLOC && !alu_res.in_heap) begin
               state_in = S_DONE;
            end else begin
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            state_in = S_DONE;
            if (req_ff.action == ACT_FREE) begin
               if (rd_hdr_ff.tag == TAG_USED) begin
                  mem_we         = 1'b1;
                  mem_wdata.tag  = TAG_FREE;
                  mem_wdata.size = rd_hdr_ff.size;
                  res_stat_in    = STAT_OK;
               end
            end else if (rd_hdr_ff.tag != TAG_FREE && rd_hdr_ff.tag != TAG_USED) begin
               state_in = S_DONE;
            end else if (alu_res.past_end) begin
               state_in = S_DONE;
            end else if (rd_hdr_ff.tag == TAG_FREE && alu_res.fits) begin
               if (alu_res.split) begin
                  // Remainder header first, the used header next cycle.
                  mem_we         = 1'b1;
                  mem_waddr      = alu_res.nxt_addr[SLOT_W+4:5];
                  mem_wdata.tag  = TAG_FREE;
                  mem_wdata.size = alu_res.rem_size;
                  state_in       = S_SPLIT;
               end else begin
                  mem_we         = 1'b1;
                  mem_wdata.tag  = TAG_USED;
                  mem_wdata.size = rd_hdr_ff.size;
                  res_addr_in    = cur_ff[15:0] + 16'(HDR_BYTES);
                  res_stat_in    = STAT_OK;
               end
            end else begin
               cur_in   = alu_res.blk_end[16:0];
               state_in = S_WALK;
            end
         end

         S_SPLIT: begin
            mem_we         = 1'b1;
            mem_wdata.tag  = TAG_USED;
            mem_wdata.size = need_ff[15:0];
            res_addr_in    = cur_ff[15:0] + 16'(HDR_BYTES);
            res_stat_in    = STAT_OK;
            state_in       = S_DONE;
         end

         // Hand the result to the output register once it is free.
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.result_addr = res_addr_ff;
               rsp_in.status      = res_stat_ff;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/ffbh_checker.sv
// ============================================================================
// ffbh_checker
// Port-level checks on the first-fit block heap, bound to the top level.
// ============================================================================
`default_nettype none

module ffbh_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire ffbh_pkg::ffbh_req_type req_payload,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire ffbh_pkg::ffbh_rsp_type rsp_payload
);
   import ffbh_pkg::*;

   // A stalled response beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response beat changed while stalled");

   // The header clearing pass keeps requests out right after reset.
   assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during the clearing pass");

   // Every failure status carries a null address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == STAT_NOFIT ||
                    rsp_payload.status == STAT_BADFREE ||
                    rsp_payload.status == STAT_NULLFREE)
      |-> rsp_payload.result_addr == '0)
      else $error("failure response with a nonzero address");

   // Heap starts and payload addresses are header aligned.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STAT_OK |-> rsp_payload.result_addr[4:0] == '0)
      else $error("unaligned address in a good response");

endmodule

bind first_fit_block_heap ffbh_checker u_ffbh_checker (.*);

`default_nettype wire
